// ===== rtl/dedup_fifo_queue_top_defines.svh =====
// assertion macros used by the top-level rtl file
`ifndef DEDUP_FIFO_QUEUE_TOP_DEFINES_SVH
`define DEDUP_FIFO_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dfq_pkg.sv =====
`default_nettype none

package dfq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 7;

  // opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_DUP   = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL  = 2'd2;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the accepted item
    logic scan;     // one step of the duplicate search
    logic rd_head;  // read the head entry
    logic commit;   // update state and write the result register
  } dfq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;  // every stored entry compared
    logic slot_free;  // result register can take a new result
  } dfq_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dfq_if.sv =====
`default_nettype none

// request channel: one operation per transfer
interface dfq_req_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [dfq_pkg::ValueW-1:0]      item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

// response channel: one result per transfer
interface dfq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [dfq_pkg::StatusW-1:0]     status;
  logic [dfq_pkg::ValueW-1:0]      head_value;
  logic [dfq_pkg::OccW-1:0]        occupancy;

  modport source (output valid, output status, output head_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input head_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dfq_datapath.sv =====
`default_nettype none

module dfq_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dfq_pkg::dfq_cmd_t           cmd_i,
  output dfq_pkg::dfq_sts_t                sts_o,
  input  wire logic                        in_op_i,
  input  wire logic [dfq_pkg::ValueW-1:0]  in_value_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [dfq_pkg::StatusW-1:0]      out_status_o,
  output logic [dfq_pkg::ValueW-1:0]       out_head_o,
  output logic [dfq_pkg::OccW-1:0]         out_occ_o
);
  import dfq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // circular storage, head is the oldest entry
  logic [ValueW-1:0] mem [DEPTH];

  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     scan_cnt_q;
  logic [AW-1:0]     scan_ptr_q;
  logic              rd_vld_q, hit_q, out_vld_q;
  logic [ValueW-1:0] rd_q;
  logic              op_q;
  logic [ValueW-1:0] val_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [ValueW-1:0] head_val_q, head_val_d;
  logic [OccW-1:0]   occ_q;

  logic          issue, full, push, pop, rd_en;
  logic [AW-1:0] rd_addr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // search and read port control
  assign issue   = (scan_cnt_q != count_q);
  assign full    = (count_q == CW'(DEPTH));
  assign rd_en   = cmd_i.rd_head | (cmd_i.scan & issue);
  assign rd_addr = cmd_i.rd_head ? head_q : scan_ptr_q;

  // result and next state at commit
  always_comb begin
    push       = 1'b0;
    pop        = 1'b0;
    status_d   = STAT_OK;
    head_val_d = '0;
    if (op_q == OP_ENQ) begin
      if (hit_q) begin
        status_d = STAT_DUP;
      end else if (full) begin
        status_d = STAT_FULL;
      end else begin
        push = 1'b1;
      end
    end else begin
      if (count_q == '0) begin
        status_d = STAT_EMPTY;
      end else begin
        pop        = 1'b1;
        head_val_d = rd_q;
      end
    end
    head_d  = pop ? ptr_inc(head_q) : head_q;
    tail_d  = push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (push) begin
      count_d = count_q + CW'(1);
    end else if (pop) begin
      count_d = count_q - CW'(1);
    end
  end

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push) begin
      mem[tail_q] <= val_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      scan_cnt_q <= '0;
      scan_ptr_q <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
        scan_ptr_q <= head_q;
        rd_vld_q   <= 1'b0;
        hit_q      <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
          scan_ptr_q <= ptr_inc(scan_ptr_q);
        end
        if (rd_vld_q && (rd_q == val_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        head_q    <= head_d;
        tail_q    <= tail_d;
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      val_q <= in_value_i;
    end
    if (cmd_i.commit) begin
      status_q   <= status_d;
      head_val_q <= head_val_d;
      occ_q      <= OccW'(count_d);
    end
  end

  assign sts_o.scan_done = !issue && !rd_vld_q;
  assign sts_o.slot_free = !out_vld_q || out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = status_q;
  assign out_head_o   = head_val_q;
  assign out_occ_o    = occ_q;

endmodule

`default_nettype wire

// ===== rtl/dfq_ctrl.sv =====
`default_nettype none

module dfq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_op_i,
  output logic                    in_ready_o,
  input  wire dfq_pkg::dfq_sts_t  sts_i,
  output dfq_pkg::dfq_cmd_t       cmd_o
);
  import dfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DREAD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // commands and next state
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_ENQ) ? S_SCAN : S_DREAD;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_DREAD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dedup_fifo_queue_top.sv =====
`default_nettype none

// First-in first-out queue of 32-bit values that stores each value at most
// once. An enqueue compares its value against every stored entry, one entry
// per cycle on the single read port of the entry memory, and then reports
// duplicate, full or appends the value. A dequeue reads the head entry. One
// item is in work at a time; the next request transfer is taken as soon as
// the result of the previous one sits in the output register, and a result
// waits there until the response side takes it. Occupancy reports the entry
// count masked to 7 bits. The entry memory needs no clearing after reset.
module dedup_fifo_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfq_req_if.sink    req_i,
  dfq_rsp_if.source  rsp_o
);
  import dfq_pkg::*;

  `include "dedup_fifo_queue_top_defines.svh"

  dfq_cmd_t cmd;
  dfq_sts_t sts;

  dfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.opcode),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (req_i.opcode),
    .in_value_i   (req_i.item_value),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_head_o   (rsp_o.head_value),
    .out_occ_o    (rsp_o.occupancy)
  );

  // one item in work at a time
  `DFQ_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready,
    "request taken while an item is in work")
  // a result never overwrites one that was not taken
  `DFQ_ASSERT_NOW(a_commit_slot_free, cmd.commit, sts.slot_free,
    "result register overwritten before transfer")
  // only a successful dequeue carries a head value
  `DFQ_ASSERT_NOW(a_head_zero, rsp_o.valid && (rsp_o.status != STAT_OK),
    rsp_o.head_value == '0, "head value set on a non-ok result")
  // each command comes alone
  `DFQ_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd),
    "more than one datapath command in a cycle")

endmodule

`default_nettype wire

// ===== sim/tb_dedup_fifo_queue_top.sv =====
`timescale 1ns / 100ps

module tb_dedup_fifo_queue_top;
  import dfq_pkg::*;

  localparam int unsigned Depth     = 64;
  localparam int unsigned MaxShown  = 10;
  localparam int unsigned RandItems = 257;

  typedef logic [ValueW-1:0] value_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    value_t             head_value;
    logic [OccW-1:0]    occupancy;
  } queue_result_t;

  // one line of the directed table; value counts up over the repeats
  typedef struct {
    logic          op;
    value_t        value;
    int unsigned   reps;
    bit            literal_exp;
    queue_result_t res;
  } stim_row_t;

  typedef enum int unsigned {
    MIX_PHASE,
    FILL_PHASE,
    DRAIN_PHASE
  } phase_mode_e;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;

  // shadow of the queue contents
  value_t      model_entries [Depth];
  int unsigned model_count;

  queue_result_t pending_results [$];
  int unsigned   fail_count;

  dfq_req_if req_if ();
  dfq_rsp_if rsp_if ();

  dedup_fifo_queue_top #(
    .DEPTH (Depth)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // stored value, small value or any value
  function automatic value_t pick_value(int unsigned dup_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (model_count != 0 && r < dup_pct) begin
      return model_entries[$urandom_range(0, model_count - 1)];
    end
    if (r < dup_pct + 15) return value_t'($urandom_range(0, 15));
    return value_t'($urandom());
  endfunction

  // expected result of one operation, advances the shadow queue
  function automatic queue_result_t predict_queue_result(logic op, value_t value);
    queue_result_t res;
    bit            found;
    res.head_value = '0;
    if (op == OP_ENQ) begin
      found = 1'b0;
      for (int i = 0; i < model_count; i++) begin
        if (model_entries[i] == value) found = 1'b1;
      end
      if (found) begin
        res.status = STAT_DUP;
      end else if (model_count >= Depth) begin
        res.status = STAT_FULL;
      end else begin
        model_entries[model_count] = value;
        model_count++;
        res.status = STAT_OK;
      end
    end else if (model_count == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.head_value = model_entries[0];
      for (int i = 0; i + 1 < model_count; i++) begin
        model_entries[i] = model_entries[i + 1];
      end
      model_count--;
      res.status = STAT_OK;
    end
    res.occupancy = model_count[OccW-1:0];
    return res;
  endfunction

  // one request transfer, with an optional idle gap in front
  task automatic send_item(logic op, value_t value, bit literal_exp, queue_result_t lit_res);
    queue_result_t res;
    int unsigned   gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.item_value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    res = predict_queue_result(op, value);
    pending_results.push_back(literal_exp ? lit_res : res);
  endtask

  // response side stalls
  initial begin : response_pacing
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.status, rsp_if.head_value, rsp_if.occupancy};
      if (pending_results.size() == 0) begin
        if (fail_count < MaxShown) begin
          $display("unexpected result: status %0d head %h occupancy %0d",
                   got.status, got.head_value, got.occupancy);
        end
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.head_value !== want.head_value ||
            got.occupancy !== want.occupancy) begin
          if (fail_count < MaxShown) begin
            $display("mismatch: status %0d/%0d head %h/%h occupancy %0d/%0d (exp/act)",
                     want.status, got.status, want.head_value, got.head_value,
                     want.occupancy, got.occupancy);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t     stim_rows [$];
    stim_row_t     row;
    phase_mode_e   mode;
    int unsigned   sent;
    int unsigned   phase;
    int unsigned   len;
    int unsigned   enq_pct;
    int unsigned   dup_pct;
    logic          op;

    req_if.valid      = 1'b0;
    req_if.opcode     = OP_ENQ;
    req_if.item_value = '0;
    no_idle           = 1'b0;
    model_count       = 0;
    fail_count        = 0;
    rst_n             = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: typed expectations where obvious, predictor elsewhere
    stim_rows = '{
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_EMPTY, 32'h0, 7'd0}},
      '{OP_ENQ, 32'h0000_0000, 1, 1'b1, {STAT_OK, 32'h0, 7'd1}},
      '{OP_ENQ, 32'hFFFF_FFFF, 1, 1'b1, {STAT_OK, 32'h0, 7'd2}},
      '{OP_ENQ, 32'h0000_0000, 1, 1'b1, {STAT_DUP, 32'h0, 7'd2}},
      '{OP_ENQ, 32'hFFFF_FFFF, 1, 1'b1, {STAT_DUP, 32'h0, 7'd2}},
      '{OP_DEQ, 32'hFFFF_FFFF, 1, 1'b1, {STAT_OK, 32'h0, 7'd1}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_OK, 32'hFFFF_FFFF, 7'd0}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_EMPTY, 32'h0, 7'd0}},
      '{OP_ENQ, 32'hAAAA_AAAA, 1, 1'b1, {STAT_OK, 32'h0, 7'd1}},
      '{OP_ENQ, 32'h5555_5555, 1, 1'b1, {STAT_OK, 32'h0, 7'd2}},
      '{OP_ENQ, 32'h8000_0000, 1, 1'b0, {STAT_OK, 32'h0, 7'd0}},
      '{OP_ENQ, 32'h0000_0001, 1, 1'b0, {STAT_OK, 32'h0, 7'd0}},
      // fill up to the last slot
      '{OP_ENQ, 32'h0000_0100, 60, 1'b0, {STAT_OK, 32'h0, 7'd0}},
      '{OP_ENQ, 32'h1234_5678, 1, 1'b1, {STAT_FULL, 32'h0, 7'd64}},
      // duplicate while full wins over full
      '{OP_ENQ, 32'h5555_5555, 1, 1'b1, {STAT_DUP, 32'h0, 7'd64}},
      '{OP_ENQ, 32'h0000_0120, 1, 1'b1, {STAT_DUP, 32'h0, 7'd64}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_OK, 32'hAAAA_AAAA, 7'd63}},
      '{OP_ENQ, 32'h1234_5678, 1, 1'b1, {STAT_OK, 32'h0, 7'd64}},
      '{OP_ENQ, 32'hAAAA_AAAA, 1, 1'b1, {STAT_FULL, 32'h0, 7'd64}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_OK, 32'h5555_5555, 7'd63}},
      // drain down to the last entry
      '{OP_DEQ, 32'h0000_0000, 62, 1'b0, {STAT_OK, 32'h0, 7'd0}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_OK, 32'h1234_5678, 7'd0}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b1, {STAT_EMPTY, 32'h0, 7'd0}}
    };

    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        send_item(row.op, value_t'(row.value + k), row.literal_exp, row.res);
      end
    end

    // random phases biased toward filling, draining or a mix
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      mode    = phase_mode_e'($urandom_range(0, 2));
      no_idle = ($urandom_range(0, 3) == 0);
      case (mode)
        FILL_PHASE: begin
          enq_pct = 90;
          dup_pct = 10;
          len     = $urandom_range(70, 100);
        end
        DRAIN_PHASE: begin
          enq_pct = 20;
          dup_pct = 40;
          len     = $urandom_range(20, 60);
        end
        default: begin
          enq_pct = 55;
          dup_pct = 40;
          len     = $urandom_range(20, 60);
        end
      endcase
      for (int k = 0; k < len && sent < RandItems; k++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_item(op, pick_value(dup_pct), 1'b0, '0);
        sent++;
      end
      // after the first phase and now and then later, hold the sender until every result is back
      if (phase == 0 || $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      phase++;
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Depth * 2) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dfq_pkg.sv
rtl/dfq_if.sv
rtl/dfq_datapath.sv
rtl/dfq_ctrl.sv
rtl/dedup_fifo_queue_top.sv
sim/tb_dedup_fifo_queue_top.sv
